// ===== design/dda_pkg.sv =====
// Shared types and constants for the DDA line rasterizer.
// No dependencies; imported by the front, queue, back and top-level modules.
`default_nettype none

package dda_pkg;

  // Kind of an input item, carried on in_tuser.
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_VIEW_W = 1'b0,
    CFG_VIEW_H = 1'b1
  } cfg_index_t;

  localparam int unsigned SCREEN_BITS = 12;
  localparam logic [SCREEN_BITS-1:0] VIEW_W_RESET = 12'd1024;
  localparam logic [SCREEN_BITS-1:0] VIEW_H_RESET = 12'd768;

  // Entries in the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    BK_IDLE,
    BK_DIVIDE
  } back_state_t;

endpackage

`default_nettype wire

// ===== design/dda_line_rasterizer.sv =====
// Top level of the DDA line rasterizer: screen size registers and the
// front / queue / back chain. Depends on dda_pkg, dda_front, dda_queue, dda_back.
//
//   Channel | Ports                  | tdata (low bit up)               | tuser / tlast
//   input   | in_tvalid/tready       | start_x, start_y, end_x, end_y   | opcode / -
//   output  | out_tvalid/tready      | pixel_x, pixel_y                 | on_screen / last_pixel
//   config  | cfg_valid/ready        | cfg_index, cfg_data              | -
//
// A start beat occupies the back while it loads and then divides, one quotient bit per
// cycle from the restoring divider whose divisor x and y share; it gives no output.
// An advance beat waits for the output register when a line is active and then yields
// one pixel beat; with no line active it is dropped.
// Input beats pass a front register and a two-entry queue first.
// Reset is synchronous and active low; screen size returns to 1024 x 768.
// The output register accepts a new pixel in the same cycle its beat is taken.
`default_nettype none

module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = 13,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_tvalid,
  output logic                                           in_tready,
  // start_x, start_y, end_x, end_y, zero pad
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]         in_tdata,
  // opcode
  input  wire logic                                      in_tuser,
  output logic                                           out_tvalid,
  input  wire logic                                      out_tready,
  // pixel_x, pixel_y, zero pad
  output logic [((2*COORD_BITS+7)/8)*8-1:0]              out_tdata,
  // on_screen
  output logic                                           out_tuser,
  output logic                                           out_tlast,
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic                                      cfg_index,
  input  wire logic [dda_pkg::SCREEN_BITS-1:0]           cfg_data
);
  import dda_pkg::*;

  localparam int unsigned C       = COORD_BITS;
  localparam int unsigned IN_W    = ((4*C+7)/8)*8;
  localparam int unsigned OUT_W   = ((2*C+7)/8)*8;
  localparam int unsigned ENTRY_W = 4*C + 3;

  logic [SCREEN_BITS-1:0] view_w_r, view_h_r;
  logic                   push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0]     push_data, pop_data;
  logic [C-1:0]           pixel_x, pixel_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_w_r <= VIEW_W_RESET;
      view_h_r <= VIEW_H_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_VIEW_W: view_w_r <= cfg_data;
        CFG_VIEW_H: view_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  dda_front #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  dda_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  dda_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .view_w        (view_w_r),
    .view_h        (view_h_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .on_screen     (out_tuser),
    .last_pixel    (out_tlast)
  );

  assign out_tdata = OUT_W'({pixel_y, pixel_x});

endmodule

`default_nettype wire

// ===== design/dda_front.sv =====
// Front end: registers an input beat and classifies it, deriving the deltas,
// their magnitudes and signs. Depends on dda_pkg.
`default_nettype none

module dda_front #(
  parameter int unsigned COORD_BITS = 13,
  parameter int unsigned IN_W       = 56,
  parameter int unsigned ENTRY_W    = 4 * 13 + 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_W-1:0]       in_tdata,
  input  wire logic                  in_tuser,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output logic [ENTRY_W-1:0]         push_data
);
  import dda_pkg::*;

  localparam int unsigned C = COORD_BITS;

  logic                  valid_r;
  logic                  valid_nxt;
  logic                  op_r;
  logic signed [C-1:0]   sx_r, sy_r, ex_r, ey_r;
  logic signed [C:0]     dx, dy;
  logic [C:0]            ax_w, ay_w;
  logic [C-1:0]          ax, ay;

  assign in_tready = !valid_r || push_ready;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r <= in_tuser;
      sx_r <= in_tdata[C-1:0];
      sy_r <= in_tdata[2*C-1:C];
      ex_r <= in_tdata[3*C-1:2*C];
      ey_r <= in_tdata[4*C-1:3*C];
    end
  end

  // The deltas never exceed 2^C-1 in magnitude, so C bits hold them.
  always_comb begin
    dx   = (C+1)'(ex_r) - (C+1)'(sx_r);
    dy   = (C+1)'(ey_r) - (C+1)'(sy_r);
    ax_w = dx[C] ? (C+1)'(-dx) : dx;
    ay_w = dy[C] ? (C+1)'(-dy) : dy;
    ax   = ax_w[C-1:0];
    ay   = ay_w[C-1:0];
  end

  assign push_valid = valid_r;
  assign push_data  = {dy[C], dx[C], ay, ax, sy_r, sx_r, op_r};

endmodule

`default_nettype wire

// ===== design/dda_queue.sv =====
// Short first-in first-out queue that decouples the front from the back.
// Depends on dda_pkg for its depth.
`default_nettype none

module dda_queue #(
  parameter int unsigned WIDTH = 55
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);
  import dda_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/dda_back.sv =====
// Back end: divides the deltas into increments one quotient bit per cycle,
// then steps the accumulators and drives the pixel output register.
// Depends on dda_pkg.
`default_nettype none

module dda_back #(
  parameter int unsigned COORD_BITS = 13,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned ENTRY_W    = 4 * 13 + 3
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                pop_valid,
  output logic                                     pop_ready,
  input  wire logic [ENTRY_W-1:0]                  pop_data,
  input  wire logic [dda_pkg::SCREEN_BITS-1:0]     view_w,
  input  wire logic [dda_pkg::SCREEN_BITS-1:0]     view_h,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [COORD_BITS-1:0]                    pixel_x,
  output logic [COORD_BITS-1:0]                    pixel_y,
  output logic                                     on_screen,
  output logic                                     last_pixel
);
  import dda_pkg::*;

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned ACC_W = C + F;
  localparam int unsigned INC_W = F + 2;
  localparam int unsigned Q_W   = F + 1;
  localparam int unsigned CNT_W = $clog2(F + 1);
  localparam int unsigned CMP_W = (C > SCREEN_BITS) ? C : SCREEN_BITS;

  back_state_t              state_r, state_nxt;
  logic                     line_active_r, line_active_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic signed [ACC_W-1:0]  acc_x_r, acc_y_r;
  logic signed [INC_W-1:0]  inc_x_r, inc_y_r;
  logic [C-1:0]             steps_left_r;
  logic [C-1:0]             divisor_r;
  logic [C:0]               rem_x_r, rem_y_r;
  logic [Q_W-1:0]           q_x_r, q_y_r;
  logic                     neg_x_r, neg_y_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [C-1:0]             pix_x_r, pix_y_r;
  logic                     on_screen_r, last_r;

  // Queue entry fields.
  logic                     e_op;
  logic [C-1:0]             e_sx, e_sy, e_ax, e_ay;
  logic                     e_nx, e_ny;
  logic [C-1:0]             e_steps;

  logic                     out_free;
  logic                     take_start, take_adv, emit;
  logic                     ge_x, ge_y;
  logic [C:0]               t_x, t_y;
  logic [Q_W-1:0]           q_x_nxt, q_y_nxt;
  logic                     div_last;
  logic [ACC_W-1:0]         tr_x, tr_y;
  logic                     in_x, in_y;

  assign e_op    = pop_data[0];
  assign e_sx    = pop_data[C:1];
  assign e_sy    = pop_data[2*C:C+1];
  assign e_ax    = pop_data[3*C:2*C+1];
  assign e_ay    = pop_data[4*C:3*C+1];
  assign e_nx    = pop_data[4*C+1];
  assign e_ny    = pop_data[4*C+2];
  assign e_steps = (e_ax > e_ay) ? e_ax : e_ay;

  assign out_free = !out_valid_r || out_ready;

  // While idle, a start is taken at once; an advance waits for the output register
  // unless no line is active, in which case it is dropped.
  always_comb begin
    take_start = 1'b0;
    take_adv   = 1'b0;
    if (state_r == BK_IDLE && pop_valid) begin
      if (opcode_t'(e_op) == OP_START) begin
        take_start = 1'b1;
      end else if (!line_active_r || out_free) begin
        take_adv = 1'b1;
      end
    end
  end

  assign pop_ready = take_start || take_adv;
  assign emit      = take_adv && line_active_r;
  assign div_last  = (state_r == BK_DIVIDE) && (cnt_r == '0);

  always_comb begin
    state_nxt       = state_r;
    line_active_nxt = line_active_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    unique case (state_r)
      BK_IDLE: begin
        if (take_start) begin
          state_nxt       = BK_DIVIDE;
          line_active_nxt = 1'b0;
        end else if (emit) begin
          out_valid_nxt = 1'b1;
          if (steps_left_r == '0) begin
            line_active_nxt = 1'b0;
          end
        end
      end
      BK_DIVIDE: begin
        if (div_last) begin
          state_nxt       = BK_IDLE;
          line_active_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_IDLE;
      line_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      line_active_r <= line_active_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Restoring division of |delta| * 2^F by steps. Since |delta| <= steps the
  // remainder starts as |delta| and the first bit carries weight 2^F.
  always_comb begin
    ge_x    = (rem_x_r >= {1'b0, divisor_r});
    ge_y    = (rem_y_r >= {1'b0, divisor_r});
    t_x     = ge_x ? rem_x_r - {1'b0, divisor_r} : rem_x_r;
    t_y     = ge_y ? rem_y_r - {1'b0, divisor_r} : rem_y_r;
    q_x_nxt = {q_x_r[Q_W-2:0], ge_x};
    q_y_nxt = {q_y_r[Q_W-2:0], ge_y};
  end

  // Truncation toward zero: bias negative values by 2^F-1 before the shift.
  always_comb begin
    tr_x = acc_x_r + {{C{1'b0}}, {F{acc_x_r[ACC_W-1]}}};
    tr_y = acc_y_r + {{C{1'b0}}, {F{acc_y_r[ACC_W-1]}}};
    in_x = !acc_x_r[ACC_W-1] &&
           (CMP_W'(acc_x_r[ACC_W-1:F]) < CMP_W'(view_w));
    in_y = !acc_y_r[ACC_W-1] &&
           (CMP_W'(acc_y_r[ACC_W-1:F]) < CMP_W'(view_h));
  end

  always_ff @(posedge clk) begin
    if (take_start) begin
      acc_x_r      <= {e_sx, {F{1'b0}}};
      acc_y_r      <= {e_sy, {F{1'b0}}};
      rem_x_r      <= {1'b0, e_ax};
      rem_y_r      <= {1'b0, e_ay};
      neg_x_r      <= e_nx;
      neg_y_r      <= e_ny;
      divisor_r    <= e_steps;
      steps_left_r <= e_steps;
      q_x_r        <= '0;
      q_y_r        <= '0;
      cnt_r        <= CNT_W'(F);
    end else if (state_r == BK_DIVIDE) begin
      rem_x_r <= {t_x[C-1:0], 1'b0};
      rem_y_r <= {t_y[C-1:0], 1'b0};
      q_x_r   <= q_x_nxt;
      q_y_r   <= q_y_nxt;
      cnt_r   <= cnt_r - 1'b1;
      if (div_last) begin
        if (divisor_r == '0) begin
          inc_x_r <= '0;
          inc_y_r <= '0;
        end else begin
          inc_x_r <= neg_x_r ? -INC_W'(q_x_nxt) : INC_W'(q_x_nxt);
          inc_y_r <= neg_y_r ? -INC_W'(q_y_nxt) : INC_W'(q_y_nxt);
        end
      end
    end else if (emit) begin
      pix_x_r     <= tr_x[ACC_W-1:F];
      pix_y_r     <= tr_y[ACC_W-1:F];
      on_screen_r <= in_x && in_y;
      last_r      <= (steps_left_r == '0);
      if (steps_left_r != '0) begin
        steps_left_r <= steps_left_r - 1'b1;
        acc_x_r      <= acc_x_r + ACC_W'(inc_x_r);
        acc_y_r      <= acc_y_r + ACC_W'(inc_y_r);
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign pixel_x    = pix_x_r;
  assign pixel_y    = pix_y_r;
  assign on_screen  = on_screen_r;
  assign last_pixel = last_r;

endmodule

`default_nettype wire

// ===== verif/dda_line_rasterizer_test.sv =====
// Self-checking testbench for dda_line_rasterizer: drives start and advance beats,
// predicts every pixel beat from its own DDA model and checks them in order.
// Depends on dda_pkg and the dda_line_rasterizer RTL.
module dda_line_rasterizer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dda_pkg::*;

  localparam int COORD_BITS = 13;
  localparam int FRAC_BITS = 16;
  localparam int ACC_BITS = COORD_BITS + FRAC_BITS + 1;
  localparam int INC_BITS = FRAC_BITS + 2;
  localparam int IN_DATA_W = ((4*COORD_BITS+7)/8)*8;
  localparam int OUT_DATA_W = ((2*COORD_BITS+7)/8)*8;
  localparam int COORD_MIN = -4096;
  localparam int COORD_MAX = 4095;
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_LIMIT = 20000;
  localparam int BEATS_PER_SEGMENT = 140;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  on_screen;
    logic                  last;
  } pixel_t;

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int larger(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int clamp(int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Tracks the line being walked and holds the pixels still owed by the block.
  class raster_tracker;
    logic [SCREEN_BITS-1:0]      screen_w;
    logic [SCREEN_BITS-1:0]      screen_h;
    bit                          line_on;
    logic signed [ACC_BITS-1:0]  acc_x;
    logic signed [ACC_BITS-1:0]  acc_y;
    logic signed [INC_BITS-1:0]  inc_x;
    logic signed [INC_BITS-1:0]  inc_y;
    logic [COORD_BITS:0]         steps_left;
    pixel_t                      pixels_due[$];
    int                          fail_count;

    function new();
      screen_w = VIEW_W_RESET;
      screen_h = VIEW_H_RESET;
      line_on = 1'b0;
      acc_x = '0;
      acc_y = '0;
      inc_x = '0;
      inc_y = '0;
      steps_left = '0;
      fail_count = 0;
    endfunction

    function void set_screen(cfg_index_t idx, logic [SCREEN_BITS-1:0] val);
      if (idx == CFG_VIEW_W) begin
        screen_w = val;
      end else begin
        screen_h = val;
      end
    endfunction

    // Per-step increment, rounded toward zero so the walk never overshoots.
    function logic signed [INC_BITS-1:0] ratio(int delta, int steps);
      int mag;
      if (steps == 0) return '0;
      mag = (magnitude(delta) << FRAC_BITS) / steps;
      return INC_BITS'((delta < 0) ? -mag : mag);
    endfunction

    function logic [COORD_BITS-1:0] whole_part(logic signed [ACC_BITS-1:0] acc);
      int a;
      int w;
      a = acc;
      w = (a >= 0) ? (a >>> FRAC_BITS) : -((-a) >>> FRAC_BITS);
      return w[COORD_BITS-1:0];
    endfunction

    function bit in_bounds(logic signed [ACC_BITS-1:0] acc, logic [SCREEN_BITS-1:0] limit);
      int a;
      a = acc;
      return (a >= 0) && ((a >>> FRAC_BITS) < int'(limit));
    endfunction

    // Returns 0 for an advance beat that the block ignores.
    function bit take_command(opcode_t op, int sx, int sy, int ex, int ey);
      int dx;
      int dy;
      int steps;
      pixel_t px;
      if (op == OP_START) begin
        dx = ex - sx;
        dy = ey - sy;
        steps = larger(magnitude(dx), magnitude(dy));
        inc_x = ratio(dx, steps);
        inc_y = ratio(dy, steps);
        acc_x = ACC_BITS'(sx * (1 << FRAC_BITS));
        acc_y = ACC_BITS'(sy * (1 << FRAC_BITS));
        steps_left = (COORD_BITS+1)'(steps);
        line_on = 1'b1;
        return 1'b1;
      end
      if (!line_on) return 1'b0;
      px.x = whole_part(acc_x);
      px.y = whole_part(acc_y);
      px.on_screen = in_bounds(acc_x, screen_w) && in_bounds(acc_y, screen_h);
      px.last = (steps_left == 0);
      if (px.last) begin
        line_on = 1'b0;
      end else begin
        steps_left = (COORD_BITS+1)'(steps_left - 1);
        acc_x = acc_x + inc_x;
        acc_y = acc_y + inc_y;
      end
      pixels_due.push_back(px);
      return 1'b1;
    endfunction

    task report(string what);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task match_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                     logic on_screen, logic last);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        report($sformatf("pixel beat (%0d,%0d) with none due", $signed(x), $signed(y)));
        return;
      end
      want = pixels_due.pop_front();
      if (x !== want.x)
        report($sformatf("pixel_x %0d, want %0d", $signed(x), $signed(want.x)));
      if (y !== want.y)
        report($sformatf("pixel_y %0d, want %0d", $signed(y), $signed(want.y)));
      if (on_screen !== want.on_screen)
        report($sformatf("on_screen %b, want %b at (%0d,%0d)", on_screen, want.on_screen,
                         $signed(want.x), $signed(want.y)));
      if (last !== want.last)
        report($sformatf("last_pixel %b, want %b at (%0d,%0d)", last, want.last,
                         $signed(want.x), $signed(want.y)));
    endtask
  endclass

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  // start_x, start_y, end_x, end_y, zero pad
  logic [IN_DATA_W-1:0]    in_tdata = '0;
  // opcode
  logic                    in_tuser = OP_START;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  // pixel_x, pixel_y, zero pad
  logic [OUT_DATA_W-1:0]   out_tdata;
  // on_screen
  logic                    out_tuser;
  logic                    out_tlast;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_index = CFG_VIEW_W;
  logic [SCREEN_BITS-1:0]  cfg_data = '0;

  raster_tracker tracker = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int live_beats = 0;

  dda_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.match_pixel(out_tdata[COORD_BITS-1:0], out_tdata[2*COORD_BITS-1:COORD_BITS],
                          out_tuser, out_tlast);
  end

  function automatic int noise_coord();
    return int'($urandom_range(8191)) - 4096;
  endfunction

  // Mix of anywhere, hugging a screen edge, and inside the screen.
  function automatic int pick_coord(int limit);
    int v;
    case ($urandom_range(2))
      0: v = noise_coord();
      1: v = ($urandom_range(1) ? limit : 0) + int'($urandom_range(16)) - 8;
      default: v = (limit > 0) ? int'($urandom_range(limit - 1)) : 0;
    endcase
    return clamp(v);
  endfunction

  task automatic send(opcode_t op, int sx, int sy, int ex, int ey);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {{(IN_DATA_W-4*COORD_BITS){1'b0}},
                 ey[COORD_BITS-1:0], ex[COORD_BITS-1:0],
                 sy[COORD_BITS-1:0], sx[COORD_BITS-1:0]};
    do @(posedge clk); while (!in_tready);
    if (tracker.take_command(op, sx, sy, ex, ey)) live_beats++;
  endtask

  // Endpoint fields of advance beats carry junk; the block must not look at them.
  task automatic draw_line(int sx, int sy, int ex, int ey, int advances);
    send(OP_START, sx, sy, ex, ey);
    repeat (advances) send(OP_ADVANCE, noise_coord(), noise_coord(), noise_coord(),
                           noise_coord());
  endtask

  task automatic write_reg(cfg_index_t idx, logic [SCREEN_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_screen(idx, val);
  endtask

  task automatic configure(logic [SCREEN_BITS-1:0] w, logic [SCREEN_BITS-1:0] h);
    write_reg(CFG_VIEW_W, w);
    write_reg(CFG_VIEW_H, h);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Start beats give no pixel, so a divide may still be running once nothing is due.
  task automatic settle();
    int waited;
    @(negedge clk);
    in_tvalid <= 1'b0;
    waited = 0;
    while (tracker.pixels_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (tracker.pixels_due.size() != 0) begin
      tracker.report($sformatf("%0d pixels never arrived", tracker.pixels_due.size()));
      tracker.pixels_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic directed_lines();
    send(OP_ADVANCE, 0, 0, 0, 0);
    draw_line(0, 0, 0, 0, 2);
    draw_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 2);
    draw_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 2);
    draw_line(-3, 5, 2, -1, 7);
    draw_line(1023, 767, 1026, 765, 4);
  endtask

  task automatic random_line();
    int kind;
    int span;
    int sx;
    int sy;
    int ex;
    int ey;
    int steps;
    int advances;
    kind = $urandom_range(99);
    if (kind < 6) begin
      send(OP_ADVANCE, noise_coord(), noise_coord(), noise_coord(), noise_coord());
      return;
    end
    span = (kind < 80) ? 12 : (kind < 95) ? 200 : 8191;
    sx = pick_coord(tracker.screen_w);
    sy = pick_coord(tracker.screen_h);
    ex = clamp(sx + int'($urandom_range(2*span)) - span);
    ey = clamp(sy + int'($urandom_range(2*span)) - span);
    steps = larger(magnitude(ex - sx), magnitude(ey - sy));
    case ($urandom_range(6))
      0: advances = $urandom_range(steps);
      1: advances = steps + 1 + int'($urandom_range(3, 1));
      default: advances = steps + 1;
    endcase
    // Long lines are mostly cut off by the next start.
    if (span > 200 && advances > 40) advances = $urandom_range(40);
    draw_line(sx, sy, ex, ey, advances);
  endtask

  initial begin
    int sx;
    int sy;
    int ex;
    int ey;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 8;
    recv_idle_pct = 76;
    directed_lines();
    settle();
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: configure(12'd4095, 12'd4095);
        1: configure(12'd1, 12'd1);
        2: configure(12'd0, 12'($urandom_range(4095, 1)));
        3: configure(12'($urandom_range(4095, 1)), 12'($urandom_range(4095, 1)));
        4: configure(12'($urandom_range(4095, 1)), 12'd0);
        default: configure(12'($urandom_range(2047, 1)), 12'($urandom_range(2047, 1)));
      endcase
      case (seg / 2)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (seg == 5) begin
        // One long line walked to its end to expose accumulated rounding.
        sx = int'($urandom_range(400)) - 1200;
        ex = sx + 300 + int'($urandom_range(40));
        sy = int'($urandom_range(3000)) - 1500;
        ey = sy + int'($urandom_range(400)) - 200;
        draw_line(sx, sy, ex, ey, larger(ex - sx, magnitude(ey - sy)) + 1);
      end
      live_beats = 0;
      while (live_beats < BEATS_PER_SEGMENT) random_line();
      settle();
    end
    if (tracker.fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
design/dda_pkg.sv
design/dda_front.sv
design/dda_queue.sv
design/dda_back.sv
design/dda_line_rasterizer.sv
verif/dda_line_rasterizer_test.sv
